/* sv/acc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types, constants and the symbol classifier of the alignment column
// classifier.
// ----------------------------------------------------------------------------
package acc_pkg;

	localparam int CNT_W     = 8;
	localparam int NUM_CLS   = 5;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] MAX_ROWS = 8'd255;

	localparam logic [CNT_W-1:0] THRESHOLD_RST  = 8'd2;
	localparam logic [CNT_W-1:0] FIRST_ROW_RST  = 8'd0;
	localparam logic [CNT_W-1:0] SECOND_ROW_RST = 8'd1;

	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_C    = 8'h43;
	localparam logic [7:0] CHAR_G    = 8'h47;
	localparam logic [7:0] CHAR_T    = 8'h54;
	localparam logic [7:0] CHAR_DASH = 8'h2d;

	typedef enum logic [2:0] {
		CLS_A    = 3'd0,
		CLS_C    = 3'd1,
		CLS_G    = 3'd2,
		CLS_T    = 3'd3,
		CLS_DASH = 3'd4,
		CLS_NONE = 3'd5
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_FIRST_ROW  = 2'd1,
		REG_SECOND_ROW = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       column_end;
	} in_item_t;

	typedef struct packed {
		logic             contributing;
		logic             two_rows_minority;
		logic [CNT_W-1:0] mismatch_count;
	} out_item_t;

	// finished column, front to back
	typedef struct packed {
		logic [NUM_CLS-1:0][CNT_W-1:0] counts;
		logic [CNT_W-1:0]              rows;
		cls_t                          first_cls;
		cls_t                          second_cls;
	} col_sum_t;

	function automatic cls_t classify(input logic [7:0] ch);
		cls_t c;
		case (ch)
			CHAR_A:    c = CLS_A;
			CHAR_C:    c = CLS_C;
			CHAR_G:    c = CLS_G;
			CHAR_T:    c = CLS_T;
			CHAR_DASH: c = CLS_DASH;
			default:   c = CLS_NONE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/acc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acc_front
// Accepts symbols, keeps the running class counts, row count and fixed-row
// classes, and pushes a column summary at the last row.
// ----------------------------------------------------------------------------
module acc_front import acc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_item,
	input  wire logic [CNT_W-1:0] first_row,
	input  wire logic [CNT_W-1:0] second_row,
	output logic                  push,
	output col_sum_t              push_data,
	input  wire logic             q_ready
);

	logic [NUM_CLS-1:0][CNT_W-1:0] cnt_q, cnt_nx;
	logic [CNT_W-1:0]              row_q, row_nx;
	cls_t                          first_q, second_q, first_nx, second_nx;
	cls_t                          cls, known;
	logic                          row_live;
	logic                          accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_item.column_end;

	always_comb begin
		cls      = classify(in_item.symbol);
		known    = (cls == CLS_NONE) ? CLS_DASH : cls;
		row_live = (row_q < MAX_ROWS);
		row_nx   = row_q + CNT_W'(row_live);
		first_nx  = (row_live && row_q == first_row) ? known : first_q;
		second_nx = (row_live && row_q == second_row) ? known : second_q;
		for (int k = 0; k < NUM_CLS; k++) begin
			cnt_nx[k] = cnt_q[k];
			if (cls == cls_t'(3'(k)) && cnt_q[k] < MAX_ROWS)
				cnt_nx[k] = cnt_q[k] + 1'b1;
		end
		push_data.counts     = cnt_nx;
		push_data.rows       = row_nx;
		push_data.first_cls  = first_nx;
		push_data.second_cls = second_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			row_q    <= '0;
			first_q  <= CLS_DASH;
			second_q <= CLS_DASH;
		end else if (accept) begin
			if (in_item.column_end) begin
				cnt_q    <= '0;
				row_q    <= '0;
				first_q  <= CLS_DASH;
				second_q <= CLS_DASH;
			end else begin
				cnt_q    <= cnt_nx;
				row_q    <= row_nx;
				first_q  <= first_nx;
				second_q <= second_nx;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/acc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acc_queue
// Short queue of column summaries between the front and the back.
// ----------------------------------------------------------------------------
module acc_queue import acc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire col_sum_t    push_data,
	output logic             push_ready,
	input  wire logic        pop,
	output logic             head_valid,
	output col_sum_t         head,
	output logic [QCNT_W-1:0] count
);

	col_sum_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_q, rd_q;
	logic [QCNT_W-1:0]    cnt_q;
	logic                 do_push, do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign count      = cnt_q;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/acc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acc_back
// Evaluates one column summary: contributing classes, the two-row minority
// test and the mismatch count, into a registered output item.
// ----------------------------------------------------------------------------
module acc_back import acc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire col_sum_t         head,
	output logic                  pop,
	input  wire logic [CNT_W-1:0] threshold,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_item
);

	logic             out_valid_q;
	out_item_t        out_q, res;
	logic [2:0]       observed;
	logic [CNT_W-1:0] fixed_cnt, best;
	logic             minority;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		observed = '0;
		for (int k = 0; k < NUM_CLS; k++)
			observed = observed + 3'(head.counts[k] >= threshold);

		fixed_cnt = head.counts[head.first_cls];
		minority  = 1'b0;
		if (head.first_cls == head.second_cls) begin
			for (int k = 0; k < NUM_CLS; k++)
				if (cls_t'(3'(k)) != head.first_cls && head.counts[k] >= fixed_cnt)
					minority = 1'b1;
		end

		// ties keep the lower class
		best = head.counts[0];
		for (int k = 1; k < NUM_CLS; k++)
			if (best < head.counts[k])
				best = head.counts[k];

		res.contributing      = (observed >= 3'd2);
		res.two_rows_minority = minority;
		res.mismatch_count    = head.rows - best;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= res;
	end

endmodule
`default_nettype wire

/* sv/alignment_column_classifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alignment_column_classifier
// Counts A/C/G/T/dash over the rows of an alignment column and reports one
// result item per column.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------
//  in       | in  | in_valid / in_ready  | in_item: symbol, column_end
//  out      | out | out_valid / out_ready| out_item: contributing,
//           |     |                      |   two_rows_minority, mismatch_count
//  cfg      | in  | cfg_we               | cfg_index, cfg_wdata
//
//  One input item per cycle while in_ready is high; a column's result goes
//  through a 2-entry summary queue and an output reg after the last row.
//  in_ready drops only while the summary queue is full.
//  Reset clears counts, queue and output valid; config returns to defaults.
//  Output stalls back up into the queue, then into the input.
// ----------------------------------------------------------------------------
module alignment_column_classifier import acc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_wdata
);

	logic [CNT_W-1:0]  threshold_q, first_row_q, second_row_q;
	logic              push, q_ready, pop, head_valid;
	col_sum_t          push_data, head;
	logic [QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			first_row_q  <= FIRST_ROW_RST;
			second_row_q <= SECOND_ROW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:  threshold_q  <= cfg_wdata;
				REG_FIRST_ROW:  first_row_q  <= cfg_wdata;
				REG_SECOND_ROW: second_row_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	acc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.first_row  (first_row_q),
		.second_row (second_row_q),
		.push       (push),
		.push_data  (push_data),
		.q_ready    (q_ready)
	);

	acc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	acc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.threshold  (threshold_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("summary queue count out of range");

	a_col_end_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.column_end) |=> (q_count != '0))
		else $error("column end did not reach the queue");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !head_valid) |=> !out_valid)
		else $error("output item repeated");

	a_pop_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !out_valid) |=> out_valid)
		else $error("queued column not moved to output");

endmodule
`default_nettype wire

/* dv/tb_alignment_column_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alignment_column_classifier
// Streams alignment columns through the classifier under random back-pressure
// and source gaps, tallies each column in a local copy of the counting logic
// and compares every per-column verdict field by field, in order.
// ----------------------------------------------------------------------------
module tb_alignment_column_classifier;
	import acc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES  = 9;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
		logic       typed;
		out_item_t  want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_wdata;

	// local column state and register copies
	logic [CNT_W-1:0] class_tally [NUM_CLS];
	logic [CNT_W-1:0] rows_seen;
	cls_t             row_a_cls;
	cls_t             row_b_cls;
	logic [CNT_W-1:0] thr_cfg;
	logic [CNT_W-1:0] row_a_cfg;
	logic [CNT_W-1:0] row_b_cfg;

	out_item_t column_verdicts_q [$];
	logic      typed_now;
	out_item_t typed_want;

	int src_idle;
	int dst_idle;
	int error_count;
	int rows_sent;
	int phase_rows;
	int columns_done;
	int verdicts_checked;
	int cycle_count;

	logic [7:0] base_chars [NUM_CLS] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_DASH};

	// directed columns; verdicts typed in where obvious, else predicted
	plan_row_t plan [22] = '{
		'{CHAR_A,    1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_A,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_A,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_C,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_C,    1'b1, 1'b1, '{1'b1, 1'b1, 8'd2}},
		'{8'h00,     1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{8'hff,     1'b1, 1'b1, '{1'b0, 1'b1, 8'd2}},
		'{CHAR_G,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_T,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_DASH, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd2}},
		'{CHAR_T,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_T,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_T,    1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_DASH, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_DASH, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{8'h61,     1'b1, 1'b1, '{1'b0, 1'b0, 8'd1}},
		'{CHAR_C,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_G,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_A,    1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{8'h80,     1'b1, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{CHAR_DASH, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
		'{8'h5a,     1'b1, 1'b1, '{1'b0, 1'b1, 8'd1}}
	};

	alignment_column_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_tally();
		for (int k = 0; k < NUM_CLS; k++) begin
			class_tally[k] = '0;
		end
		rows_seen = '0;
		row_a_cls = CLS_DASH;
		row_b_cls = CLS_DASH;
	endtask

	task automatic tally_row(input in_item_t it, output logic done, output out_item_t res);
		cls_t c;
		cls_t seen;
		int   hits;
		int   best;
		int   fixed;
		logic minority;
		case (it.symbol)
			CHAR_A:    c = CLS_A;
			CHAR_C:    c = CLS_C;
			CHAR_G:    c = CLS_G;
			CHAR_T:    c = CLS_T;
			CHAR_DASH: c = CLS_DASH;
			default:   c = CLS_NONE;
		endcase
		seen = (c == CLS_NONE) ? CLS_DASH : c;
		if (rows_seen < MAX_ROWS) begin
			if (rows_seen == row_a_cfg) row_a_cls = seen;
			if (rows_seen == row_b_cfg) row_b_cls = seen;
			rows_seen = rows_seen + 8'd1;
		end
		if (c != CLS_NONE && class_tally[int'(c)] < MAX_ROWS)
			class_tally[int'(c)] = class_tally[int'(c)] + 8'd1;
		done = it.column_end;
		res = '0;
		if (done) begin
			hits = 0;
			for (int k = 0; k < NUM_CLS; k++) begin
				if (class_tally[k] >= thr_cfg) hits++;
			end
			minority = 1'b0;
			if (row_a_cls == row_b_cls) begin
				fixed = int'(row_a_cls);
				for (int k = 0; k < NUM_CLS; k++) begin
					if (k != fixed && class_tally[k] >= class_tally[fixed]) minority = 1'b1;
				end
			end
			best = 0;
			for (int k = 1; k < NUM_CLS; k++) begin
				if (class_tally[best] < class_tally[k]) best = k;
			end
			res.contributing      = (hits >= 2);
			res.two_rows_minority = minority;
			res.mismatch_count    = rows_seen - class_tally[best];
			clear_tally();
		end
	endtask

	// input acceptance first, so a verdict is queued before it can be checked
	always @(posedge clk) begin
		logic      done;
		out_item_t res;
		out_item_t want;
		if (arst_n && in_valid && in_ready) begin
			tally_row(in_item, done, res);
			if (done) begin
				column_verdicts_q.push_back(typed_now ? typed_want : res);
				columns_done++;
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (column_verdicts_q.size() == 0) begin
				$display("%0t: unexpected item %h", $time, out_item);
				error_count++;
			end else begin
				want = column_verdicts_q.pop_front();
				verdicts_checked++;
				if (out_item.contributing !== want.contributing) begin
					$display("%0t: contributing exp %0d got %0d", $time,
						want.contributing, out_item.contributing);
					error_count++;
				end
				if (out_item.two_rows_minority !== want.two_rows_minority) begin
					$display("%0t: two_rows_minority exp %0d got %0d", $time,
						want.two_rows_minority, out_item.two_rows_minority);
					error_count++;
				end
				if (out_item.mismatch_count !== want.mismatch_count) begin
					$display("%0t: mismatch_count exp %0d got %0d", $time,
						want.mismatch_count, out_item.mismatch_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= dst_idle);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d verdicts outstanding", $time, column_verdicts_q.size());
			$display("tb_alignment_column_classifier NOT OK");
			$finish;
		end
	end

	task automatic send_row(input logic [7:0] sym, input logic last, input logic typed,
			input out_item_t want);
		if ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
		end
		in_valid   <= 1'b1;
		in_item    <= '{symbol: sym, column_end: last};
		typed_now  <= typed;
		typed_want <= want;
		do @(posedge clk); while (!in_ready);
		rows_sent++;
		phase_rows++;
	endtask

	task automatic run_column(input int len, input logic wide);
		int f0;
		int f1;
		int r;
		logic [7:0] sym;
		f0 = $urandom_range(0, NUM_CLS - 1);
		f1 = $urandom_range(0, NUM_CLS - 1);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < (wide ? 96 : 70))
				sym = base_chars[$urandom_range(0, 1) ? f0 : f1];
			else if (r < 88)
				sym = base_chars[$urandom_range(0, NUM_CLS - 1)];
			else
				sym = 8'($urandom_range(0, 255));
			send_row(sym, i == len - 1, 1'b0, '0);
		end
	endtask

	// drop valid, drain verdicts, then let the pipe go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (column_verdicts_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] thr, input logic [7:0] ra,
			input logic [7:0] rb);
		cfg_we    <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= REG_FIRST_ROW;
		cfg_wdata <= ra;
		@(posedge clk);
		cfg_index <= REG_SECOND_ROW;
		cfg_wdata <= rb;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= CNT_W'($urandom_range(0, 255));
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_cfg   = thr;
		row_a_cfg = ra;
		row_b_cfg = rb;
	endtask

	initial begin
		int         len;
		int         target;
		logic       wide;
		logic [7:0] thr;
		logic [7:0] ra;
		logic [7:0] rb;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_item    = '0;
		typed_now  = 1'b0;
		typed_want = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_THRESHOLD;
		cfg_wdata  = '0;
		out_ready  = 1'b0;
		src_idle   = 28;
		dst_idle   = 74;
		thr_cfg    = THRESHOLD_RST;
		row_a_cfg  = FIRST_ROW_RST;
		row_b_cfg  = SECOND_ROW_RST;
		clear_tally();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(plan); i++) begin
			send_row(plan[i].sym, plan[i].last, plan[i].typed, plan[i].want);
		end
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				src_idle = 28;
				dst_idle = 74;
			end else if (p < 6) begin
				src_idle = 74;
				dst_idle = 28;
			end else begin
				src_idle = 0;
				dst_idle = 0;
			end
			case (p)
				0: begin thr = 8'd255; ra = 8'd254; rb = 8'd254; end
				1: begin thr = 8'd0;   ra = 8'd0;   rb = 8'd0;   end
				2: begin thr = 8'd1;   ra = 8'd254; rb = 8'd255; end
				3: begin thr = 8'd3;   ra = 8'd2;   rb = 8'd2;   end
				default: begin
					thr = 8'($urandom_range(0, 6));
					ra  = 8'($urandom_range(0, 10));
					rb  = $urandom_range(0, 1) ? ra : 8'($urandom_range(0, 10));
				end
			endcase
			apply_config(thr, ra, rb);
			phase_rows = 0;
			target = (p == 0) ? 400 : 100;
			while (phase_rows < target) begin
				wide = ((p == 0 || p == 2) && $urandom_range(0, 5) == 0);
				if (wide)
					len = $urandom_range(250, 560);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 12);
				run_column(len, wide);
			end
			settle();
		end

		$display("%0d rows sent in %0d columns over %0d register settings", rows_sent,
			columns_done, NUM_PHASES + 1);
		$display("%0d verdicts checked, %0d errors", verdicts_checked, error_count);
		if (error_count == 0)
			$display("tb_alignment_column_classifier OK");
		else
			$display("tb_alignment_column_classifier NOT OK");
		$finish;
	end

endmodule
